>>> design/crse_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the catmull-rom spline evaluator
// no dependencies; imported by every module of the block but crse_ram

package crse_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_W        = 32;
	localparam int COUNT_W        = 7;
	localparam int INDEX_W        = 6;
	localparam int TIME_W         = 17;
	localparam int FRAC_BITS      = 16;
	// horner accumulator width, holds 2*p1 plus all weighted terms
	localparam int HW             = 40;
	localparam int POINT_W        = 3 * COORD_W;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd4;
	localparam logic [TIME_W-1:0]  T_ONE       = 17'h10000;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_EVAL  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_COEF,
		ST_HORNER,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		HS_B,
		HS_A,
		HS_D
	} horner_step_t;

	typedef struct packed {
		logic         shift;
		logic         load_coef;
		logic         step;
		horner_step_t sel;
	} axis_ctrl_t;

endpackage

>>> design/crse_ram.sv
`timescale 1ns / 1ps
// generic simple dual port ram, one write and one registered read port
// no dependencies

module crse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/crse_axis.sv
`timescale 1ns / 1ps
// one axis of the evaluator: point window, coefficients, horner iteration
// depends on crse_pkg

module crse_axis import crse_pkg::*; (
	input  logic                      clk,
	input  axis_ctrl_t                ctrl,
	input  logic signed [COORD_W-1:0] rd_data,
	input  logic        [TIME_W-1:0]  t,
	output logic signed [COORD_W-1:0] last_pt,
	output logic signed [COORD_W-1:0] result
);

	localparam int PW = HW + TIME_W + 1;
	localparam logic signed [PW-1:0] HALF_LSB = PW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [HW:0] SAT_MAX = (HW+1)'(32'sh7fffffff);
	localparam logic signed [HW:0] SAT_MIN = -(HW+1)'(33'sh080000000);

	logic signed [COORD_W-1:0] p0_q, p1_q, p2_q, p3_q;
	logic signed [HW-1:0] a_q, b_q, d_q, h_q;
	logic signed [HW-1:0] e0, e1, e2, e3;
	logic signed [HW-1:0] coef;
	logic signed [PW-1:0] prod, prod_r;
	logic signed [HW:0]   h_inc, h_half;

	assign e0 = HW'(p0_q);
	assign e1 = HW'(p1_q);
	assign e2 = HW'(p2_q);
	assign e3 = HW'(p3_q);

	always_comb begin
		case (ctrl.sel)
			HS_B:    coef = b_q;
			HS_A:    coef = a_q;
			HS_D:    coef = d_q;
			default: coef = d_q;
		endcase
	end

	// round half up: floor((h*t + 0.5) / 1.0)
	assign prod   = h_q * $signed({1'b0, t});
	assign prod_r = (prod + HALF_LSB) >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			p0_q <= p1_q;
			p1_q <= p2_q;
			p2_q <= p3_q;
			p3_q <= rd_data;
		end
		if (ctrl.load_coef) begin
			a_q <= e2 - e0;
			b_q <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
			d_q <= e1 <<< 1;
			h_q <= (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;
		end else if (ctrl.step) begin
			h_q <= coef + prod_r[HW-1:0];
		end
	end

	assign h_inc  = (HW+1)'(h_q) + (HW+1)'(1);
	assign h_half = h_inc >>> 1;

	always_comb begin
		if (h_half > SAT_MAX) begin
			result = 32'sh7fffffff;
		end else if (h_half < SAT_MIN) begin
			result = 32'sh80000000;
		end else begin
			result = h_half[COORD_W-1:0];
		end
	end

	assign last_pt = p3_q;

endmodule

>>> design/catmull_rom_spline_eval.sv
`timescale 1ns / 1ps
// catmull-rom spline evaluator: point table in ram, three axis units
// write word: input not stalled after it. evaluate word, accept to out_valid:
// four ram reads, drain, coefficients, three horner steps, output load;
// end-point: one read, drain, output load. next word taken as out_valid rises
// arst_n clears control state and sets point_count to 4; ram is not cleared
// depends on crse_pkg, crse_ram, crse_axis

module catmull_rom_spline_eval import crse_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic        [COUNT_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      mode,
	input  logic        [INDEX_W-1:0] point_index,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	input  logic signed [COORD_W-1:0] coord_z,
	input  logic        [TIME_W-1:0]  time_fraction,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [COORD_W-1:0] out_x,
	output logic signed [COORD_W-1:0] out_y,
	output logic signed [COORD_W-1:0] out_z
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int IW = ((AW > COUNT_W) ? AW : COUNT_W) + 1;
	localparam logic [IW-1:0] MAXP = IW'(MAX_POINTS);
	localparam logic [IW-1:0] CMIN = IW'(4);

	state_t state_q, state_d;
	logic [COUNT_W-1:0] point_count_q;
	logic [1:0]         cnt_q, cnt_d;
	logic [AW-1:0]      base_q;
	logic               pass_q;
	logic [TIME_W-1:0]  t_q;
	logic               rd_vld_s1;
	logic               out_valid_q;

	logic          accept, wr_accept, ev_accept, out_load;
	logic [IW-1:0] idx_w, cnt_w, cnt_c, last_w, base_w;
	logic          pass_d;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [POINT_W-1:0] rd_data;
	axis_ctrl_t    ctrl;
	logic signed [COORD_W-1:0] last_x, last_y, last_z, res_x, res_y, res_z;

	assign accept    = in_valid && !in_stall;
	assign wr_accept = accept && (mode == MODE_WRITE) && (idx_w < MAXP);
	assign ev_accept = accept && (mode == MODE_EVAL);

	assign idx_w = IW'(point_index);
	assign cnt_w = IW'(point_count_q);

	always_comb begin
		if (cnt_w < CMIN) begin
			cnt_c = CMIN;
		end else if (cnt_w > MAXP) begin
			cnt_c = MAXP;
		end else begin
			cnt_c = cnt_w;
		end
		last_w = cnt_c - IW'(2);
		pass_d = (idx_w == '0) || (idx_w >= last_w);
		if (idx_w == '0) begin
			base_w = IW'(1);
		end else if (pass_d) begin
			base_w = last_w;
		end else begin
			base_w = idx_w - IW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			point_count_q <= COUNT_RESET;
			rd_vld_s1     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			rd_vld_s1 <= rd_en;
			if (cfg_wr_en) begin
				point_count_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ev_accept) begin
			base_q <= base_w[AW-1:0];
			pass_q <= pass_d;
			t_q    <= (time_fraction > T_ONE) ? T_ONE : time_fraction;
		end
		if (out_load) begin
			out_x <= pass_q ? last_x : res_x;
			out_y <= pass_q ? last_y : res_y;
			out_z <= pass_q ? last_z : res_z;
		end
	end

	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		rd_en          = 1'b0;
		out_load       = 1'b0;
		ctrl.shift     = rd_vld_s1;
		ctrl.load_coef = 1'b0;
		ctrl.step      = 1'b0;
		ctrl.sel       = HS_B;
		case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (ev_accept) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				rd_en = 1'b1;
				if (pass_q || cnt_q == 2'd3) begin
					state_d = ST_DRAIN;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 2'd1;
				end
			end
			ST_DRAIN: begin
				state_d = pass_q ? ST_FINISH : ST_COEF;
			end
			ST_COEF: begin
				ctrl.load_coef = 1'b1;
				state_d        = ST_HORNER;
			end
			ST_HORNER: begin
				ctrl.step = 1'b1;
				case (cnt_q)
					2'd0:    ctrl.sel = HS_B;
					2'd1:    ctrl.sel = HS_A;
					default: ctrl.sel = HS_D;
				endcase
				if (cnt_q == 2'd2) begin
					state_d = ST_FINISH;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 2'd1;
				end
			end
			ST_FINISH: begin
				// wait until the output register is free
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rd_addr = base_q + AW'(cnt_q);

	crse_ram #(
		.WIDTH(POINT_W),
		.DEPTH(MAX_POINTS)
	) u_ram (
		.clk  (clk),
		.we   (wr_accept),
		.waddr(idx_w[AW-1:0]),
		.wdata({coord_z, coord_y, coord_x}),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	crse_axis u_axis_x (
		.clk    (clk),
		.ctrl   (ctrl),
		.rd_data(rd_data[COORD_W-1:0]),
		.t      (t_q),
		.last_pt(last_x),
		.result (res_x)
	);

	crse_axis u_axis_y (
		.clk    (clk),
		.ctrl   (ctrl),
		.rd_data(rd_data[2*COORD_W-1:COORD_W]),
		.t      (t_q),
		.last_pt(last_y),
		.result (res_y)
	);

	crse_axis u_axis_z (
		.clk    (clk),
		.ctrl   (ctrl),
		.rd_data(rd_data[3*COORD_W-1:2*COORD_W]),
		.t      (t_q),
		.last_pt(last_z),
		.result (res_z)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> design/crse_checker.sv
`timescale 1ns / 1ps
// port-level checks of the spline evaluator, bound to the top level
// depends on crse_pkg and catmull_rom_spline_eval

module crse_checker import crse_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      mode,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic signed [COORD_W-1:0] out_x,
	input logic signed [COORD_W-1:0] out_y,
	input logic signed [COORD_W-1:0] out_z
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_z))
		else $error("stalled output word changed");

	// an evaluate word keeps the block busy
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == MODE_EVAL |=> in_stall)
		else $error("input not stalled after evaluate word");

	// a write word leaves the input unstalled
	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == MODE_WRITE |=> !in_stall)
		else $error("input stalled after write word");

	// a new result only comes out of a busy evaluation
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without evaluation");

endmodule

bind catmull_rom_spline_eval crse_checker u_crse_checker (.*);

>>> verif/catmull_rom_spline_eval_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the catmull-rom spline evaluator: directed table, then random words
// checks every result against a typed or horner-predicted value; depends on crse_pkg and the rtl

module catmull_rom_spline_eval_tb import crse_pkg::*;;

	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASE_WORDS   = 54;

	localparam logic signed [COORD_W-1:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [COORD_W-1:0] S32_MIN = 32'sh80000000;
	localparam logic signed [COORD_W-1:0] ONES    = 32'shffffffff;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	typedef struct packed {
		logic               mode;
		logic [INDEX_W-1:0] idx;
		point_t             p;
		logic [TIME_W-1:0]  t;
		bit                 typed;
		point_t             want;
	} spline_word_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wr_en;
	logic        [COUNT_W-1:0] cfg_wr_data;
	logic                      in_valid;
	logic                      in_stall;
	logic                      mode;
	logic        [INDEX_W-1:0] point_index;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic signed [COORD_W-1:0] coord_z;
	logic        [TIME_W-1:0]  time_fraction;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic signed [COORD_W-1:0] out_z;

	// predictor state: control point table and point count
	logic signed [COORD_W-1:0] knot_x [MAX_POINTS_DEF];
	logic signed [COORD_W-1:0] knot_y [MAX_POINTS_DEF];
	logic signed [COORD_W-1:0] knot_z [MAX_POINTS_DEF];
	logic        [COUNT_W-1:0] count_reg;

	point_t       pending_points [$];
	spline_word_t directed_words [$];
	int           phase_counts [10] = '{64, 127, 0, 5, 17, 65, 3, 33, 64, 4};

	int mismatches;
	int cycle_count;
	int stall_left;
	bit stall_early;
	bit calm;

	catmull_rom_spline_eval i_dut (
		.clk,
		.arst_n,
		.cfg_wr_en,
		.cfg_wr_data,
		.in_valid,
		.in_stall,
		.mode,
		.point_index,
		.coord_x,
		.coord_y,
		.coord_z,
		.time_fraction,
		.out_valid,
		.out_stall,
		.out_x,
		.out_y,
		.out_z
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	// q16 product rounded half up
	function automatic longint round_q16(input longint h, input longint t);
		return (h * t + 64'sd32768) >>> 16;
	endfunction

	function automatic logic signed [COORD_W-1:0] curve_axis(input longint p0, input longint p1,
			input longint p2, input longint p3, input longint t);
		longint a;
		longint b;
		longint c;
		longint h;
		a = p2 - p0;
		b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
		c = -p0 + 3 * p1 - 3 * p2 + p3;
		h = b + round_q16(c, t);
		h = a + round_q16(h, t);
		h = 2 * p1 + round_q16(h, t);
		h = (h + 1) >>> 1;
		if (h > longint'(S32_MAX))
			return S32_MAX;
		if (h < longint'(S32_MIN))
			return S32_MIN;
		return h[COORD_W-1:0];
	endfunction

	// updates the table on a write word; returns 1 with the point on an evaluate word
	function automatic bit eval_curve_word(input spline_word_t w, output point_t r);
		int     cnt;
		int     last;
		int     i;
		longint t;
		r = '0;
		if (w.mode == MODE_WRITE) begin
			knot_x[w.idx] = w.p.x;
			knot_y[w.idx] = w.p.y;
			knot_z[w.idx] = w.p.z;
			return 1'b0;
		end
		cnt = int'(count_reg);
		if (cnt < 4)
			cnt = 4;
		if (cnt > MAX_POINTS_DEF)
			cnt = MAX_POINTS_DEF;
		last = cnt - 2;
		i = int'(w.idx);
		if (i >= last || i < 1) begin
			i = (i < 1) ? 1 : last;
			r.x = knot_x[i];
			r.y = knot_y[i];
			r.z = knot_z[i];
			return 1'b1;
		end
		t = longint'(w.t);
		if (t > longint'(T_ONE))
			t = longint'(T_ONE);
		r.x = curve_axis(longint'(knot_x[i-1]), longint'(knot_x[i]),
			longint'(knot_x[i+1]), longint'(knot_x[i+2]), t);
		r.y = curve_axis(longint'(knot_y[i-1]), longint'(knot_y[i]),
			longint'(knot_y[i+1]), longint'(knot_y[i+2]), t);
		r.z = curve_axis(longint'(knot_z[i-1]), longint'(knot_z[i]),
			longint'(knot_z[i+1]), longint'(knot_z[i+2]), t);
		return 1'b1;
	endfunction

	task automatic add_row(input logic m, input int idx, input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y, input logic signed [COORD_W-1:0] z,
			input int t, input bit typed, input logic signed [COORD_W-1:0] wx,
			input logic signed [COORD_W-1:0] wy, input logic signed [COORD_W-1:0] wz);
		spline_word_t w;
		w.mode   = m;
		w.idx    = INDEX_W'(idx);
		w.p.x    = x;
		w.p.y    = y;
		w.p.z    = z;
		w.t      = TIME_W'(t);
		w.typed  = typed;
		w.want.x = wx;
		w.want.y = wy;
		w.want.z = wz;
		directed_words.push_back(w);
	endtask

	function automatic logic signed [COORD_W-1:0] random_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? S32_MAX : S32_MIN;
			default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
		endcase
	endfunction

	function automatic spline_word_t random_word();
		spline_word_t w;
		int           cnt;
		cnt = int'(count_reg);
		if (cnt < 4)
			cnt = 4;
		if (cnt > MAX_POINTS_DEF)
			cnt = MAX_POINTS_DEF;
		w       = '0;
		w.mode  = ($urandom_range(0, 99) < 35) ? MODE_WRITE : MODE_EVAL;
		w.p.x   = random_coord();
		w.p.y   = random_coord();
		w.p.z   = random_coord();
		w.typed = 1'b0;
		// most evaluates land on an inner segment, the rest anywhere
		if (w.mode == MODE_WRITE || $urandom_range(0, 3) == 0)
			w.idx = INDEX_W'($urandom_range(0, MAX_POINTS_DEF - 1));
		else
			w.idx = INDEX_W'($urandom_range(1, cnt - 3));
		case ($urandom_range(0, 9))
			0: w.t = '0;
			1: w.t = T_ONE;
			2: w.t = TIME_W'($urandom_range(32'h10001, 32'h1ffff));
			default: w.t = TIME_W'($urandom_range(0, 32'h10000));
		endcase
		return w;
	endfunction

	task automatic send_word(input spline_word_t w);
		int     gap;
		point_t res;
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		gap = calm ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      = 1'b1;
		mode          = w.mode;
		point_index   = w.idx;
		coord_x       = w.p.x;
		coord_y       = w.p.y;
		coord_z       = w.p.z;
		time_fraction = w.t;
		do
			@(posedge clk);
		while (in_stall);
		if (eval_curve_word(w, res))
			pending_points.push_back(w.typed ? w.want : res);
	endtask

	// wait until every result is back and a trailing write has settled
	task automatic drain_block();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_point_count(input logic [COUNT_W-1:0] c);
		drain_block();
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = c;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		count_reg = c;
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		in_valid      = 1'b0;
		mode          = MODE_WRITE;
		point_index   = '0;
		coord_x       = '0;
		coord_y       = '0;
		coord_z       = '0;
		time_fraction = '0;
		out_stall     = 1'b0;
		mismatches    = 0;
		cycle_count   = 0;
		stall_left    = 0;
		stall_early   = 1'b0;
		calm          = 1'b0;
		count_reg     = COUNT_RESET;
		foreach (knot_x[k]) begin
			knot_x[k] = '0;
			knot_y[k] = '0;
			knot_z[k] = '0;
		end

		// extremes on the four points in use after reset
		add_row(MODE_WRITE, 0, S32_MIN, S32_MAX, 0, 0, 0, 0, 0, 0);
		add_row(MODE_WRITE, 1, S32_MAX, S32_MIN, ONES, 0, 0, 0, 0, 0);
		add_row(MODE_WRITE, 2, S32_MIN, S32_MAX, 1, 0, 0, 0, 0, 0);
		add_row(MODE_WRITE, 3, 32'sh12345678, 32'shfffe8000, 32'sh00010000, 0, 0, 0, 0, 0);
		// index below one, at the last segment and far beyond
		add_row(MODE_EVAL, 0, 0, 0, 0, 'h1ffff, 1, S32_MAX, S32_MIN, ONES);
		add_row(MODE_EVAL, 2, 0, 0, 0, 'h08000, 1, S32_MIN, S32_MAX, 1);
		add_row(MODE_EVAL, 63, 0, 0, 0, 0, 1, S32_MIN, S32_MAX, 1);
		// t of zero gives p1, t of one and above gives p2
		add_row(MODE_EVAL, 1, 0, 0, 0, 0, 1, S32_MAX, S32_MIN, ONES);
		add_row(MODE_EVAL, 1, 0, 0, 0, 'h10000, 1, S32_MIN, S32_MAX, 1);
		add_row(MODE_EVAL, 1, 0, 0, 0, 'h1ffff, 1, S32_MIN, S32_MAX, 1);
		add_row(MODE_EVAL, 1, 0, 0, 0, 'h08000, 0, 0, 0, 0);
		add_row(MODE_EVAL, 1, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(MODE_EVAL, 1, 0, 0, 0, 'h0ffff, 0, 0, 0, 0);
		add_row(MODE_WRITE, 1, 32'sh00010000, 32'shffff0000, 32'sh00008000, 0, 0, 0, 0, 0);
		add_row(MODE_WRITE, 2, 32'sh00020000, 32'sh00030000, 32'shffff8000, 0, 0, 0, 0, 0);
		add_row(MODE_WRITE, 0, 32'sh7fff0000, 32'sh80010000, 1, 0, 0, 0, 0, 0);
		add_row(MODE_EVAL, 1, 0, 0, 0, 'h04000, 0, 0, 0, 0);
		add_row(MODE_EVAL, 1, 0, 0, 0, 'h10001, 1, 32'sh00020000, 32'sh00030000,
			32'shffff8000);
		add_row(MODE_EVAL, 1, 0, 0, 0, 'h0c000, 0, 0, 0, 0);
		add_row(MODE_EVAL, 0, 0, 0, 0, 0, 1, 32'sh00010000, 32'shffff0000, 32'sh00008000);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_words[k])
			send_word(directed_words[k]);

		// fill the whole table so no evaluate can touch an unwritten entry
		for (int k = 0; k < MAX_POINTS_DEF; k++) begin
			spline_word_t w;
			w      = random_word();
			w.mode = MODE_WRITE;
			w.idx  = INDEX_W'(k);
			send_word(w);
		end

		foreach (phase_counts[k]) begin
			set_point_count(COUNT_W'(phase_counts[k]));
			repeat (PHASE_WORDS) send_word(random_word());
		end

		drain_block();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// result side stall, either right away or once a word is offered
	always @(negedge clk) begin
		if (stall_left > 0 && (out_valid || stall_early)) begin
			out_stall = 1'b1;
			stall_left--;
		end else begin
			out_stall = 1'b0;
		end
	end

	always @(posedge clk) begin : check_out
		point_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_points.size() == 0) begin
				report_mismatch($sformatf("unexpected result word x=%0d y=%0d z=%0d",
					out_x, out_y, out_z));
			end else begin
				want = pending_points.pop_front();
				if (out_x !== want.x)
					report_mismatch($sformatf("out_x got %0d want %0d", out_x, want.x));
				if (out_y !== want.y)
					report_mismatch($sformatf("out_y got %0d want %0d", out_y, want.y));
				if (out_z !== want.z)
					report_mismatch($sformatf("out_z got %0d want %0d", out_z, want.z));
			end
			stall_left  = calm ? 0 : $urandom_range(0, 3);
			stall_early = 1'($urandom_range(0, 1));
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule

>>> files.f
design/crse_pkg.sv
design/crse_ram.sv
design/crse_axis.sv
design/catmull_rom_spline_eval.sv
design/crse_checker.sv
verif/catmull_rom_spline_eval_tb.sv
